// File: design/log_bucket_latency_histogram_defines.svh
// ----------------------------------------------------------------------------
// log_bucket_latency_histogram_defines -- assertion macros
// Shared concurrent assertion forms for the histogram RTL.
// ----------------------------------------------------------------------------
`ifndef LOG_BUCKET_LATENCY_HISTOGRAM_DEFINES_SVH
`define LOG_BUCKET_LATENCY_HISTOGRAM_DEFINES_SVH

// same-cycle implication
`define LBH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg -- log bucket latency histogram package
// Field widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lbh_pkg;

   localparam int DUR_W   = 48;
   localparam int CNT_W   = 32;
   localparam int TOT_W   = 64;
   localparam int CSR_W   = 5;
   localparam int BIDX_W  = 4;

   localparam logic [DUR_W-1:0] BOUND_MAX = {DUR_W{1'b1}};

   // register indexes
   localparam logic CSR_GROWTH_BASE    = 1'b0;
   localparam logic CSR_BUCKETS_IN_USE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic start;     // load duration, restart walk at bucket 0
      logic step;      // advance bucket index and bound
      logic rd_en;     // read bucket entry
      logic wr_en;     // write updated bucket entry
      logic load_out;  // load result register from read entry
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;       // duration fits current bucket
      logic is_last;   // current bucket is the unbounded one
      logic out_free;  // result register can take a new transaction
   } status_type;

endpackage

`default_nettype wire

// File: design/log_bucket_latency_histogram.sv
// ----------------------------------------------------------------------------
// log_bucket_latency_histogram -- geometric-bucket latency histogram
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request channel. req_mode 0 collects req_duration_us into the
//            first bucket whose bound (1, b, b^2, ... us) covers it; req_mode 1
//            flushes every bucket in use, in index order, clearing each.
//   rsp_*  : one transaction per bucket on a flush, rsp_last on the final
//            (unbounded) bucket. Collect produces no transaction.
//   csr_*  : index 0 growth_base, index 1 buckets_in_use; always ready.
//            Write only while the block is idle.
// Sequence:
//   Collect: accept, then one bound compared per cycle from bucket 0 up to
//            the covering bucket, then a write-back of count and total.
//            The shared bound multiply-compare paces the walk.
//   Flush:   per bucket a store read, then a result load that waits on a
//            full result register; the single store read port sets the pace.
//   A new request is taken only when the previous one is finished.
// Reset: clears all buckets at once through per-entry valid bits, result
//   channel empty, registers back to base 10 and 16 buckets.
// Stall: the result register holds its transaction while rsp_ready is low;
//   the flush sweep waits on it and resumes when it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module log_bucket_latency_histogram #(
   parameter int MAX_BUCKETS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_mode,
   input  wire logic [lbh_pkg::DUR_W-1:0]  req_duration_us,
   // result channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [lbh_pkg::BIDX_W-1:0] rsp_bucket_index,
   output      logic [lbh_pkg::DUR_W-1:0]  rsp_upper_bound_us,
   output      logic                       rsp_is_unbounded,
   output      logic [lbh_pkg::CNT_W-1:0]  rsp_hit_count,
   output      logic [lbh_pkg::TOT_W-1:0]  rsp_total_us,
   output      logic                       rsp_last,
   // configuration channel
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [lbh_pkg::CSR_W-1:0]  csr_wdata
);

   import lbh_pkg::*;

   // configuration registers
   logic [CSR_W-1:0] growth_base_ff, growth_base_in;
   logic [CSR_W-1:0] buckets_ff, buckets_in;

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      growth_base_in = growth_base_ff;
      buckets_in     = buckets_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GROWTH_BASE:    growth_base_in = csr_wdata;
            CSR_BUCKETS_IN_USE: buckets_in     = csr_wdata;
            default: begin
               growth_base_in = growth_base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_base_ff <= CSR_W'(10);
         buckets_ff     <= CSR_W'(16);
      end else begin
         growth_base_ff <= growth_base_in;
         buckets_ff     <= buckets_in;
      end
   end

   // sequencing: collect walk and flush sweep
   lbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // bound walk, bucket store and result register
   lbh_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .growth_base        (growth_base_ff),
      .buckets_in_use     (buckets_ff),
      .req_duration_us    (req_duration_us),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_bucket_index   (rsp_bucket_index),
      .rsp_upper_bound_us (rsp_upper_bound_us),
      .rsp_is_unbounded   (rsp_is_unbounded),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_total_us       (rsp_total_us),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// File: design/lbh_ram.sv
// ----------------------------------------------------------------------------
// lbh_ram -- generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/lbh_datapath.sv
// ----------------------------------------------------------------------------
// lbh_datapath -- histogram datapath
// Bucket walk (index, bound), bucket store with valid bits, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "log_bucket_latency_histogram_defines.svh"

module lbh_datapath #(
   parameter int MAX_BUCKETS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lbh_pkg::cmd_type           cmd,
   output      lbh_pkg::status_type        status,
   input  wire logic [lbh_pkg::CSR_W-1:0]  growth_base,
   input  wire logic [lbh_pkg::CSR_W-1:0]  buckets_in_use,
   input  wire logic [lbh_pkg::DUR_W-1:0]  req_duration_us,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_valid,
   output      logic [lbh_pkg::BIDX_W-1:0] rsp_bucket_index,
   output      logic [lbh_pkg::DUR_W-1:0]  rsp_upper_bound_us,
   output      logic                       rsp_is_unbounded,
   output      logic [lbh_pkg::CNT_W-1:0]  rsp_hit_count,
   output      logic [lbh_pkg::TOT_W-1:0]  rsp_total_us,
   output      logic                       rsp_last
);

   import lbh_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BUCKETS);
   localparam int ENT_W  = CNT_W + TOT_W;
   localparam int PROD_W = DUR_W + CSR_W;
   localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(MAX_BUCKETS - 1);

   // walk state
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [DUR_W-1:0]       bound_ff, bound_in;
   logic [DUR_W-1:0]       dur_ff, dur_in;
   logic [MAX_BUCKETS-1:0] valid_ff, valid_in;

   // effective configuration
   logic [CSR_W-1:0] base_eff;
   logic [IDX_W-1:0] last_idx;
   logic             is_last;

   logic [PROD_W-1:0] prod;
   logic [DUR_W-1:0]  next_bound;

   // bucket store
   logic [ENT_W-1:0] rd_data;
   logic [ENT_W-1:0] wr_data;
   logic [CNT_W-1:0] ent_count;
   logic [TOT_W-1:0] ent_total;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BIDX_W-1:0]   idx_out_ff, idx_out_in;
   logic [DUR_W-1:0]    bound_out_ff, bound_out_in;
   logic                unb_out_ff, unb_out_in;
   logic [CNT_W-1:0]    count_out_ff, count_out_in;
   logic [TOT_W-1:0]    total_out_ff, total_out_in;

   always_comb begin
      priority if (growth_base < CSR_W'(2)) begin
         base_eff = CSR_W'(2);
      end else if (growth_base > CSR_W'(16)) begin
         base_eff = CSR_W'(16);
      end else begin
         base_eff = growth_base;
      end
   end

   always_comb begin
      priority if (buckets_in_use < CSR_W'(2)) begin
         last_idx = IDX_W'(1);
      end else if (32'(buckets_in_use) > 32'(MAX_BUCKETS)) begin
         last_idx = LAST_MAX;
      end else begin
         last_idx = IDX_W'(buckets_in_use - CSR_W'(1));
      end
   end

   assign is_last = (k_ff == last_idx);

   // one multiply per step; saturate once past the field maximum
   assign prod       = PROD_W'(bound_ff) * PROD_W'(base_eff);
   assign next_bound = (prod > PROD_W'(BOUND_MAX)) ? BOUND_MAX : prod[DUR_W-1:0];

   assign status.hit      = is_last || (dur_ff <= bound_ff);
   assign status.is_last  = is_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // entries never written since reset or flush read as zero
   assign ent_count = valid_ff[k_ff] ? rd_data[ENT_W-1:TOT_W] : '0;
   assign ent_total = valid_ff[k_ff] ? rd_data[TOT_W-1:0]     : '0;
   assign wr_data   = {ent_count + CNT_W'(1), ent_total + TOT_W'(dur_ff)};

   lbh_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_BUCKETS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (k_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      k_in     = k_ff;
      bound_in = bound_ff;
      dur_in   = dur_ff;
      valid_in = valid_ff;
      if (cmd.start) begin
         k_in     = '0;
         bound_in = DUR_W'(1);
         dur_in   = req_duration_us;
      end else if (cmd.step) begin
         k_in     = k_ff + IDX_W'(1);
         bound_in = next_bound;
      end
      if (cmd.wr_en) begin
         valid_in[k_ff] = 1'b1;
      end else if (cmd.load_out) begin
         valid_in[k_ff] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_out_in   = idx_out_ff;
      bound_out_in = bound_out_ff;
      unb_out_in   = unb_out_ff;
      count_out_in = count_out_ff;
      total_out_in = total_out_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         idx_out_in   = BIDX_W'(k_ff);
         bound_out_in = is_last ? BOUND_MAX : bound_ff;
         unb_out_in   = is_last;
         count_out_in = ent_count;
         total_out_in = ent_total;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      bound_ff     <= bound_in;
      dur_ff       <= dur_in;
      idx_out_ff   <= idx_out_in;
      bound_out_ff <= bound_out_in;
      unb_out_ff   <= unb_out_in;
      count_out_ff <= count_out_in;
      total_out_ff <= total_out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bucket_index   = idx_out_ff;
   assign rsp_upper_bound_us = bound_out_ff;
   assign rsp_is_unbounded   = unb_out_ff;
   assign rsp_hit_count      = count_out_ff;
   assign rsp_total_us       = total_out_ff;
   assign rsp_last           = unb_out_ff;

   `LBH_ASSERT_IMPLY(a_out_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready, "result register overwritten while stalled")
   `LBH_ASSERT_IMPLY(a_read_in_range, clock, reset, cmd.rd_en, k_ff <= last_idx, "bucket read beyond last bucket in use")
   `LBH_ASSERT_NEXT(a_bound_grows, clock, reset, cmd.step && !cmd.start, bound_ff >= $past(bound_ff), "bucket bound decreased on step")

endmodule

`default_nettype wire

// File: design/lbh_ctrl.sv
// ----------------------------------------------------------------------------
// lbh_ctrl -- histogram controller
// Sequences bound walk and bucket update for collect, bucket sweep for flush.
// ----------------------------------------------------------------------------
`default_nettype none
`include "log_bucket_latency_histogram_defines.svh"

module lbh_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_mode,
   output      logic                req_ready,
   input  wire lbh_pkg::status_type status,
   output      lbh_pkg::cmd_type    cmd
);

   import lbh_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_SCAN = 3'd1;  // compare against one bound per cycle
   localparam logic [2:0] ST_UPD  = 3'd2;  // write back count and total
   localparam logic [2:0] ST_FRD  = 3'd3;  // flush: read bucket
   localparam logic [2:0] ST_FLD  = 3'd4;  // flush: load result, clear bucket

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = req_mode ? ST_FRD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_UPD;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_UPD: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_FRD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FLD;
         end
         ST_FLD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  state_in = ST_FRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LBH_ASSERT_IMPLY(a_upd_after_scan, clock, reset, state_ff == ST_UPD, $past(state_ff) == ST_SCAN, "bucket update without a finished scan")

endmodule

`default_nettype wire
